FILE: hw/rtl/interval_set_tracker_core_assert.svh
// Assertion macros for the interval set tracker.
`ifndef INTERVAL_SET_TRACKER_CORE_ASSERT_SVH
`define INTERVAL_SET_TRACKER_CORE_ASSERT_SVH
// Implication checked on every edge outside reset.
`define IST_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define IST_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: hw/rtl/ist_pkg.sv
// Package: types, constants and command codes of the interval set tracker.
package ist_pkg;
	localparam int MaxIntervals = 64;
	localparam int CoordWidth = 32;
	localparam int IdxW = $clog2(MaxIntervals);
	localparam int CntW = $clog2(MaxIntervals + 1);

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	typedef logic [CoordWidth-1:0] coord_t;
	typedef logic [IdxW-1:0] idx_t;
	typedef logic [CntW-1:0] cnt_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [31:0] range_start;
		logic [31:0] range_end;
	} in_item_t;

	typedef struct packed {
		logic covered;
		logic overflow;
		logic [6:0] interval_count;
	} out_item_t;

	// datapath ops
	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_LOAD = 3'd1;
	localparam logic [2:0] OP_READ = 3'd2;
	localparam logic [2:0] OP_STEP = 3'd3;
	localparam logic [2:0] OP_FINAL = 3'd4;
	localparam logic [2:0] OP_SHIFT = 3'd5;
	localparam logic [2:0] OP_DONE = 3'd6;

	typedef struct packed {
		logic [2:0] op;
	} ctl_t;

	typedef struct packed {
		logic scan_end;
		logic need_shift;
		logic shift_end;
	} sts_t;
endpackage

FILE: hw/rtl/ist_ctrl.sv
// Controller: sequences scan, table update and shift passes.
module ist_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input ist_pkg::sts_t sts,
	output ist_pkg::ctl_t ctl,
	output logic busy
);
	import ist_pkg::*;
	`include "interval_set_tracker_core_assert.svh"

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_FIN = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (start) state_q <= S_READ;
				S_READ: state_q <= S_SCAN;
				S_SCAN: if (sts.scan_end) state_q <= S_FIN; else state_q <= S_READ;
				S_FIN: state_q <= sts.need_shift ? S_SHIFT : S_DONE;
				S_SHIFT: if (sts.shift_end) state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		case (state_q)
			S_IDLE: ctl.op = start ? OP_LOAD : OP_NONE;
			S_READ: ctl.op = OP_READ;
			S_SCAN: ctl.op = OP_STEP;
			S_FIN: ctl.op = OP_FINAL;
			S_SHIFT: ctl.op = OP_SHIFT;
			S_DONE: ctl.op = OP_DONE;
			default: ctl.op = OP_NONE;
		endcase
	end
	assign busy = (state_q != S_IDLE);

	`IST_ASSERT_NXT(a_start_read, state_q == S_IDLE && start, state_q == S_READ)
	`IST_ASSERT_NXT(a_done_idle, state_q == S_DONE, state_q == S_IDLE)
	`IST_ASSERT_IMP(a_busy_load, ctl.op == OP_LOAD, !busy)
endmodule

FILE: hw/rtl/ist_dp.sv
// Datapath: interval tables, scan pointer, merge/split and shift logic.
module ist_dp (
	input logic clk,
	input logic arst_n,
	input ist_pkg::ctl_t ctl,
	input ist_pkg::in_item_t item_in,
	output ist_pkg::sts_t sts,
	output logic done,
	output ist_pkg::out_item_t result
);
	import ist_pkg::*;
	`include "interval_set_tracker_core_assert.svh"

	coord_t st_mem [MaxIntervals];
	coord_t en_mem [MaxIntervals];

	logic [1:0] cmd_q;
	coord_t a_q, b_q;
	cnt_t cnt_q;
	cnt_t ptr_q;
	logic ph_q;          // 0: finding lo, 1: finding hi
	cnt_t lo_q, hi_q;
	coord_t rs_q, re_q;  // read data
	coord_t lo_s_q, hi_e_q;
	logic cov_q, ovf_q;
	// shift: dest = src + delta; direction
	cnt_t src_q, dst_q, stop_q;
	logic up_q;          // moving toward higher index
	logic wr_en;
	idx_t wr_idx;
	coord_t wr_s, wr_e;
	logic [1:0] pc_q;    // pending pieces to write after shift
	coord_t p0s_q, p0e_q, p1s_q, p1e_q;
	cnt_t pbase_q;
	logic wpend_q;
	logic wr2;
	idx_t wr2_idx;

	cnt_t rd_ptr;
	cnt_t sh_rd;
	logic in_range;
	logic cond;
	logic empty_q;

	assign in_range = ptr_q < cnt_q;
	assign rd_ptr = ptr_q;
	// up moves read src-1 into dst-1
	assign sh_rd = up_q ? src_q - cnt_t'(1) : src_q;

	always_ff @(posedge clk) begin
		if (ctl.op == OP_READ && in_range) begin
			rs_q <= st_mem[rd_ptr[IdxW-1:0]];
			re_q <= en_mem[rd_ptr[IdxW-1:0]];
		end
		if (ctl.op == OP_SHIFT && src_q != stop_q) begin
			rs_q <= st_mem[sh_rd[IdxW-1:0]];
			re_q <= en_mem[sh_rd[IdxW-1:0]];
		end
		if (wr_en) begin
			st_mem[wr_idx] <= wr_s;
			en_mem[wr_idx] <= wr_e;
		end
		if (wr2) begin
			st_mem[wr2_idx] <= p1s_q;
			en_mem[wr2_idx] <= p1e_q;
		end
	end

	// scan condition on current entry
	always_comb begin
		cond = 1'b0;
		if (in_range) begin
			case (cmd_q)
				CMD_ADD: cond = ph_q ? (rs_q <= b_q) : (re_q < a_q);
				CMD_REMOVE: cond = ph_q ? (rs_q < b_q) : (re_q <= a_q);
				CMD_QUERY: cond = (rs_q <= a_q);
				default: cond = 1'b0;
			endcase
		end
	end

	logic scan_stop;
	assign scan_stop = (ph_q || cmd_q == CMD_QUERY) && !cond;
	assign sts.scan_end = scan_stop;

	// final decision
	cnt_t removed, newcnt, dst0;
	logic [1:0] pieces;
	logic pa, pb;
	always_comb begin
		removed = hi_q - lo_q;
		pa = lo_s_q < a_q;
		pb = hi_e_q > b_q;
		pieces = {1'b0, pa} + {1'b0, pb};
		newcnt = cnt_q;
		dst0 = hi_q;
		case (cmd_q)
			CMD_ADD: begin
				dst0 = lo_q + cnt_t'(1);
				newcnt = cnt_q - removed + cnt_t'(1);
			end
			CMD_REMOVE: begin
				dst0 = lo_q + cnt_t'(pieces);
				newcnt = cnt_q - removed + cnt_t'(pieces);
			end
			default: ;
		endcase
	end

	logic fin_ok;
	always_comb begin
		fin_ok = 1'b0;
		case (cmd_q)
			CMD_ADD: fin_ok = !empty_q && !(hi_q == lo_q && cnt_q >= cnt_t'(MaxIntervals));
			CMD_REMOVE: fin_ok = !empty_q && (hi_q != lo_q) &&
				!(cnt_q - removed + cnt_t'(pieces) > cnt_t'(MaxIntervals));
			default: fin_ok = 1'b0;
		endcase
	end
	assign sts.need_shift = fin_ok && (dst0 != hi_q) && (hi_q != cnt_q);
	assign sts.shift_end = (src_q == stop_q) && !wpend_q;

	// writes
	always_comb begin
		wr_en = 1'b0;
		wr_idx = '0;
		wr_s = rs_q;
		wr_e = re_q;
		if (ctl.op == OP_SHIFT && wpend_q) begin
			wr_en = 1'b1;
			wr_idx = dst_q[IdxW-1:0];
		end else if (ctl.op == OP_DONE && pc_q != 2'd0) begin
			wr_en = 1'b1;
			wr_idx = pbase_q[IdxW-1:0];
			wr_s = p0s_q;
			wr_e = p0e_q;
		end
	end
	// second piece of a split goes in beside the first
	assign wr2 = (ctl.op == OP_DONE && pc_q == 2'd2);
	assign wr2_idx = pbase_q[IdxW-1:0] + idx_t'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done <= 1'b0;
			wpend_q <= 1'b0;
			pc_q <= 2'd0;
		end else begin
			done <= 1'b0;
			case (ctl.op)
				OP_LOAD: begin
					cmd_q <= item_in.cmd;
					a_q <= item_in.range_start;
					b_q <= item_in.range_end;
					empty_q <= !(item_in.range_start < item_in.range_end);
					ptr_q <= '0;
					ph_q <= 1'b0;
					cov_q <= 1'b0;
					ovf_q <= 1'b0;
					pc_q <= 2'd0;
					wpend_q <= 1'b0;
				end
				OP_STEP: begin
					if (cmd_q == CMD_QUERY) begin
						if (!cond) begin
							cov_q <= (ptr_q != '0) && (hi_e_q >= b_q);
						end else begin
							hi_e_q <= re_q;
							ptr_q <= ptr_q + cnt_t'(1);
						end
					end else if (!ph_q) begin
						if (cond) begin
							ptr_q <= ptr_q + cnt_t'(1);
						end else begin
							ph_q <= 1'b1;
							lo_q <= ptr_q;
							lo_s_q <= rs_q;
						end
					end else begin
						if (cond) begin
							hi_e_q <= re_q;
							ptr_q <= ptr_q + cnt_t'(1);
						end else begin
							hi_q <= ptr_q;
						end
					end
				end
				OP_FINAL: begin
					src_q <= hi_q;
					dst_q <= dst0;
					up_q <= dst0 > hi_q;
					stop_q <= cnt_q;
					if (dst0 > hi_q) begin
						src_q <= cnt_q;
						dst_q <= cnt_q + (dst0 - hi_q) - cnt_t'(1);
						stop_q <= hi_q;
					end
					if (fin_ok) begin
						cnt_q <= newcnt;
						pbase_q <= lo_q;
						if (cmd_q == CMD_ADD) begin
							pc_q <= 2'd1;
							p0s_q <= (hi_q != lo_q && lo_s_q < a_q) ? lo_s_q : a_q;
							p0e_q <= (hi_q != lo_q && hi_e_q > b_q) ? hi_e_q : b_q;
						end else begin
							pc_q <= pieces;
							if (pa) begin
								p0s_q <= lo_s_q;
								p0e_q <= a_q;
								p1s_q <= b_q;
								p1e_q <= hi_e_q;
							end else begin
								p0s_q <= b_q;
								p0e_q <= hi_e_q;
							end
						end
					end else begin
						ovf_q <= !empty_q && ((cmd_q == CMD_ADD) ||
							(cmd_q == CMD_REMOVE && hi_q != lo_q));
					end
				end
				OP_SHIFT: begin
					if (up_q) begin
						if (src_q != stop_q) begin
							src_q <= src_q - cnt_t'(1);
							wpend_q <= 1'b1;
						end else begin
							wpend_q <= 1'b0;
						end
						if (wpend_q) dst_q <= dst_q - cnt_t'(1);
					end else begin
						if (src_q != stop_q) begin
							src_q <= src_q + cnt_t'(1);
							wpend_q <= 1'b1;
						end else begin
							wpend_q <= 1'b0;
						end
						if (wpend_q) dst_q <= dst_q + cnt_t'(1);
					end
				end
				OP_DONE: begin
					done <= 1'b1;
					pc_q <= 2'd0;
				end
				default: ;
			endcase
		end
	end

	assign result.covered = cov_q;
	assign result.overflow = ovf_q;
	assign result.interval_count = 7'(cnt_q);

	`IST_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= cnt_t'(MaxIntervals))
	`IST_ASSERT_IMP(a_done_excl, done, !(cov_q && ovf_q))
	`IST_ASSERT_NXT(a_load_clear, ctl.op == OP_LOAD, !done)
endmodule

FILE: hw/rtl/interval_set_tracker_core.sv
// Top level of the interval set tracker.
// Usage: present cmd/range_start/range_end on item_in and raise start while
// busy is low; the item is taken at that edge and busy rises.
// The controller scans the stored table one entry at a time, reading and then
// testing each, to find the affected span, decides the update, then moves the
// table tail one entry per cycle before writing the new pieces. When finished,
// done pulses for one cycle with the result on result; busy falls in the same
// cycle. The block takes one item at a time, paced by the scan loop and the
// tail move.
// Reset clears the entry count; table contents need no clearing.
// The receiver cannot stall: each result is flagged by done for exactly one cycle.
module interval_set_tracker_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	input ist_pkg::in_item_t item_in,
	output logic busy,
	output logic done,
	output ist_pkg::out_item_t result
);
	import ist_pkg::*;

	ctl_t ctl;
	sts_t sts;

	ist_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .ctl(ctl), .busy(busy)
	);
	ist_dp u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .item_in(item_in), .sts(sts),
		.done(done), .result(result)
	);
endmodule

FILE: tb/interval_set_tracker_core_checker.sv
// Checker for the interval set tracker: predicts each result and compares it.
`timescale 1ns / 1ps
module interval_set_tracker_core_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input ist_pkg::in_item_t item_in,
	input ist_pkg::out_item_t result,
	output int fail_count,
	output int pending
);
	import ist_pkg::*;

	logic [31:0] span_lo [MaxIntervals];
	logic [31:0] span_hi [MaxIntervals];
	int span_count;
	out_item_t expected_results [$];

	function automatic void move_spans(int from, int to);
		if (from == to) begin
			return;
		end
		if (to > from) begin
			for (int i = span_count - 1; i >= from; i--) begin
				span_lo[i + to - from] = span_lo[i];
				span_hi[i + to - from] = span_hi[i];
			end
		end else begin
			for (int i = from; i < span_count; i++) begin
				span_lo[i + to - from] = span_lo[i];
				span_hi[i + to - from] = span_hi[i];
			end
		end
	endfunction

	function automatic logic add_span(logic [31:0] a, logic [31:0] b);
		int lo;
		int hi;
		logic [31:0] s;
		logic [31:0] e;
		lo = 0;
		if (a >= b) begin
			return 1'b0;
		end
		while (lo < span_count && span_hi[lo] < a) begin
			lo++;
		end
		hi = lo;
		while (hi < span_count && span_lo[hi] <= b) begin
			hi++;
		end
		if (hi > lo) begin
			s = span_lo[lo] < a ? span_lo[lo] : a;
			e = span_hi[hi - 1] > b ? span_hi[hi - 1] : b;
			move_spans(hi, lo + 1);
			span_count -= hi - lo - 1;
			span_lo[lo] = s;
			span_hi[lo] = e;
			return 1'b0;
		end
		if (span_count >= MaxIntervals) begin
			return 1'b1;
		end
		move_spans(lo, lo + 1);
		span_count++;
		span_lo[lo] = a;
		span_hi[lo] = b;
		return 1'b0;
	endfunction

	function automatic logic cut_span(logic [31:0] a, logic [31:0] b);
		int lo;
		int hi;
		int pieces;
		logic [31:0] ps [2];
		logic [31:0] pe [2];
		lo = 0;
		pieces = 0;
		if (a >= b) begin
			return 1'b0;
		end
		while (lo < span_count && span_hi[lo] <= a) begin
			lo++;
		end
		hi = lo;
		while (hi < span_count && span_lo[hi] < b) begin
			hi++;
		end
		if (hi == lo) begin
			return 1'b0;
		end
		if (span_lo[lo] < a) begin
			ps[pieces] = span_lo[lo];
			pe[pieces] = a;
			pieces++;
		end
		if (span_hi[hi - 1] > b) begin
			ps[pieces] = b;
			pe[pieces] = span_hi[hi - 1];
			pieces++;
		end
		if (span_count - (hi - lo) + pieces > MaxIntervals) begin
			return 1'b1;
		end
		move_spans(hi, lo + pieces);
		span_count = span_count - (hi - lo) + pieces;
		for (int p = 0; p < pieces; p++) begin
			span_lo[lo + p] = ps[p];
			span_hi[lo + p] = pe[p];
		end
		return 1'b0;
	endfunction

	function automatic logic span_covers(logic [31:0] a, logic [31:0] b);
		int i;
		i = 0;
		while (i < span_count && span_lo[i] <= a) begin
			i++;
		end
		if (i == 0) begin
			return 1'b0;
		end
		return span_hi[i - 1] >= b;
	endfunction

	function automatic out_item_t predict_result(in_item_t it);
		out_item_t r;
		r = '0;
		case (it.cmd)
			CMD_ADD: begin
				r.overflow = add_span(it.range_start, it.range_end);
			end
			CMD_REMOVE: begin
				r.overflow = cut_span(it.range_start, it.range_end);
			end
			CMD_QUERY: begin
				r.covered = span_covers(it.range_start, it.range_end);
			end
			default: begin
			end
		endcase
		r.interval_count = 7'(span_count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			span_count = 0;
			fail_count = 0;
			expected_results.delete();
			pending = 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result %p", $time, result);
				end else begin
					want = expected_results.pop_front();
					if (result.covered !== want.covered
							|| result.overflow !== want.overflow
							|| result.interval_count !== want.interval_count) begin
						fail_count++;
						$display("%0t: expected %p actual %p", $time, want, result);
					end
				end
			end
			if (start && !busy) begin
				expected_results.push_back(predict_result(item_in));
			end
			pending = expected_results.size();
		end
	end
endmodule

FILE: tb/interval_set_tracker_core_test.sv
// Testbench top for the interval set tracker: stimulus and verdict.
`timescale 1ns / 1ps
module interval_set_tracker_core_test;
	import ist_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	in_item_t item_in;
	logic busy;
	logic done;
	out_item_t result;
	int fail_count;
	int pending;
	longint cycle_count = 0;

	interval_set_tracker_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item_in(item_in),
		.busy(busy),
		.done(done),
		.result(result)
	);

	interval_set_tracker_core_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.item_in(item_in),
		.result(result),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("interval_set_tracker_core verification failed");
			$finish;
		end
	end

	task automatic send_item(logic [1:0] c, logic [31:0] a, logic [31:0] b);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) begin
			gap = 0;
		end
		@(posedge clk);
		repeat (gap) @(posedge clk);
		start <= 1'b1;
		item_in <= '{cmd: c, range_start: a, range_end: b};
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		start <= 1'b0;
	endtask

	task automatic drain();
		do begin
			@(posedge clk);
		end while (pending != 0);
	endtask

	task automatic send_random(int base, int spread);
		logic [1:0] c;
		logic [31:0] a;
		logic [31:0] len;
		int r;
		r = $urandom_range(0, 99);
		c = r < 45 ? CMD_ADD : r < 75 ? CMD_REMOVE : r < 97 ? CMD_QUERY : 2'd3;
		a = 32'(base) + $urandom_range(0, spread);
		len = $urandom_range(0, spread / 8 + 2);
		if ($urandom_range(0, 19) == 0) begin
			send_item(c, $urandom, $urandom);
		end else begin
			send_item(c, a, a + len);
		end
	endtask

	initial begin
		start = 1'b0;
		item_in = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_item(CMD_QUERY, 32'd5, 32'd6);
		send_item(CMD_ADD, 32'd10, 32'd20);
		send_item(CMD_ADD, 32'd20, 32'd30);
		send_item(CMD_ADD, 32'd40, 32'd40);
		send_item(CMD_ADD, 32'd50, 32'd45);
		send_item(CMD_QUERY, 32'd12, 32'd30);
		send_item(CMD_QUERY, 32'd12, 32'd31);
		send_item(CMD_QUERY, 32'd15, 32'd15);
		send_item(CMD_REMOVE, 32'd15, 32'd18);
		send_item(CMD_REMOVE, 32'd5, 32'd10);
		send_item(CMD_REMOVE, 32'd29, 32'd18);
		send_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(CMD_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
		send_item(CMD_ADD, 32'd0, 32'd1);
		send_item(CMD_QUERY, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_item(CMD_REMOVE, 32'd0, 32'hFFFF_FFFF);
		for (int i = 0; i < 64; i++) begin
			send_item(CMD_ADD, 32'(i * 10), 32'(i * 10 + 5));
		end
		send_item(CMD_ADD, 32'd1000, 32'd1001);
		send_item(CMD_ADD, 32'd5, 32'd10);
		send_item(CMD_ADD, 32'd1000, 32'd1001);
		send_item(CMD_REMOVE, 32'd11, 32'd12);
		send_item(CMD_REMOVE, 32'd20, 32'd21);
		send_item(CMD_REMOVE, 32'd22, 32'd23);
		drain();
		for (int i = 0; i < 665; i++) begin
			if (i == 350) begin
				send_item(CMD_REMOVE, 32'd0, 32'hFFFF_FFFF);
			end
			if (i % 250 == 125) begin
				drain();
			end
			send_random(i < 500 ? 0 : 32'hFFFF_F000, i % 3 == 0 ? 4000 : 700);
		end
		drain();
		repeat (250) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("interval_set_tracker_core verification clean");
		end else begin
			$display("interval_set_tracker_core verification failed");
		end
		$finish;
	end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ist_pkg.sv
hw/rtl/ist_ctrl.sv
hw/rtl/ist_dp.sv
hw/rtl/interval_set_tracker_core.sv
tb/interval_set_tracker_core_checker.sv
tb/interval_set_tracker_core_test.sv
